// ===== rtl/core/prq_pkg.sv =====
`timescale 1ns / 1ps
// prq_pkg: shared types and constants for the priority ready queue
// no dependencies; imported by priority_ready_queue_unit

package prq_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH      = 3'd0,
        CMD_PRIO_PUSH = 3'd1,
        CMD_POP       = 3'd2,
        CMD_REMOVE    = 3'd3,
        CMD_QUERY     = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_EV,
        S_UP_RD,
        S_UP_WR,
        S_INS,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/priority_ready_queue_unit.sv =====
`timescale 1ns / 1ps
// priority_ready_queue_unit: ordered task queue with a sequenced walk over slot memory
// depends on prq_pkg
//
// Usage:
//   input channel  i_valid / o_ready carries one command word: i_command,
//   i_task_id, i_task_priority. output channel o_valid / i_ready carries one
//   result word per command: o_result_id, o_result_valid, o_status, o_found,
//   o_now_empty.
//   Entries live in one slot memory ({id, priority} per slot, head at slot 0)
//   with one write and one registered read per cycle. A small sequencer
//   drives a single compare unit and the memory port. A push writes at the
//   tail; a priority push scans for the first entry of lower priority, moves
//   the later entries up one slot and writes into the gap (or at the tail);
//   pop and remove scan to the entry and move the later ones down; query
//   scans until a hit. A pop, remove or query on an empty queue, or a push
//   into a full one, ends without a walk. o_ready is high only between
//   commands. The result sits in an output register, so the next command is
//   taken while a result waits; a stalled receiver holds the sequencer at its
//   last step once a second result is due. Reset empties the queue (slot
//   contents are left as they are), drops o_valid and leaves o_ready high.

module priority_ready_queue_unit
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int PRIO_BITS   = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [ID_W-1:0]     i_task_id,
    input  logic [PRIO_W-1:0]   i_task_priority,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [ID_W-1:0]     o_result_id,
    output logic                o_result_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_found,
    output logic                o_now_empty
);

    localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX = (ID_BITS > ID_W) ? ID_BITS : ID_W;
    localparam int PRX = (PRIO_BITS > PRIO_W) ? PRIO_BITS : PRIO_W;
    localparam int DW  = ID_BITS + PRIO_BITS;

    // slot memory, {id, priority}
    logic [DW-1:0] r_mem [QUEUE_DEPTH];
    logic [DW-1:0] r_rd;

    t_state r_state, n_state;
    logic [CW-1:0]        r_occ, n_occ;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_pos, n_pos;
    logic [CMD_W-1:0]     r_cmd;
    logic [ID_BITS-1:0]   r_id;
    logic [PRIO_BITS-1:0] r_prio;
    logic [ID_BITS-1:0]   r_res_id, n_res_id;
    logic                 r_res_valid, n_res_valid;
    t_status              r_status, n_status;
    logic                 r_found, n_found;
    logic                 r_first, n_first;

    logic                r_out_valid;
    logic [ID_W-1:0]     r_out_id;
    logic                r_out_rvalid;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_found;
    logic                r_out_empty;

    logic                 w_accept;
    logic                 w_out_load;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_scan_last;
    logic                 w_dn_last;
    logic                 w_up_last;
    logic                 w_hit;
    logic [CW-1:0]        w_idx_p1;
    logic [CW-1:0]        w_idx_m1;
    logic [ID_BITS-1:0]   w_rd_id;
    logic [PRIO_BITS-1:0] w_rd_prio;
    logic [IDX-1:0]       w_id_in;
    logic [PRX-1:0]       w_prio_in;
    logic [IDX-1:0]       w_res_ext;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [DW-1:0]        w_wr_data;

    assign w_accept   = i_valid && o_ready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    assign w_id_in   = IDX'(i_task_id);
    assign w_prio_in = PRX'(i_task_priority);
    assign w_res_ext = IDX'(r_res_id);

    assign w_full      = (r_occ == CW'(QUEUE_DEPTH));
    assign w_empty     = (r_occ == '0);
    assign w_idx_p1    = r_idx + CW'(1);
    assign w_idx_m1    = r_idx - CW'(1);
    assign w_scan_last = (w_idx_p1 >= r_occ);
    assign w_dn_last   = ((r_idx + CW'(2)) >= r_occ);
    assign w_up_last   = (r_idx == (r_pos + CW'(1)));

    assign w_rd_id   = r_rd[DW-1:PRIO_BITS];
    assign w_rd_prio = r_rd[PRIO_BITS-1:0];

    // shared compare unit
    always_comb begin
        unique case (r_cmd)
            CMD_PRIO_PUSH: w_hit = (r_prio > w_rd_prio);
            CMD_POP:       w_hit = 1'b1;
            default:       w_hit = (w_rd_id == r_id);
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_START;
            end
            S_START: begin
                unique case (r_cmd)
                    CMD_PUSH:      n_state = w_full ? S_DONE : S_INS;
                    CMD_PRIO_PUSH: n_state = w_full ? S_DONE : (w_empty ? S_INS : S_SCAN_RD);
                    CMD_POP, CMD_REMOVE, CMD_QUERY: begin
                        n_state = w_empty ? S_DONE : S_SCAN_RD;
                    end
                    default:       n_state = S_DONE;
                endcase
            end
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV: begin
                if (w_hit) begin
                    unique case (r_cmd)
                        CMD_PRIO_PUSH: n_state = S_UP_RD;
                        CMD_QUERY:     n_state = S_DONE;
                        default:       n_state = w_scan_last ? S_DONE : S_DN_RD;
                    endcase
                end else if (w_scan_last) begin
                    n_state = (r_cmd == CMD_PRIO_PUSH) ? S_INS : S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_UP_RD: n_state = S_UP_WR;
            S_UP_WR: n_state = w_up_last ? S_INS : S_UP_RD;
            S_INS:   n_state = S_DONE;
            S_DN_RD: n_state = S_DN_WR;
            S_DN_WR: n_state = w_dn_last ? S_DONE : S_DN_RD;
            S_DONE: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory port control
    always_comb begin
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_res_id    = r_res_id;
        n_res_valid = r_res_valid;
        n_status    = r_status;
        n_found     = r_found;
        n_first     = r_first;
        w_rd_addr   = r_idx[AW-1:0];
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx[AW-1:0];
        w_wr_data   = r_rd;
        unique case (r_state)
            S_IDLE: begin
                n_res_id    = '0;
                n_res_valid = 1'b0;
                n_status    = ST_OK;
                n_found     = 1'b0;
                n_first     = 1'b0;
                n_idx       = '0;
            end
            S_START: begin
                n_pos = r_occ;
                unique case (r_cmd)
                    CMD_PUSH, CMD_PRIO_PUSH: begin
                        if (w_full) n_status = ST_FULL;
                    end
                    CMD_POP, CMD_REMOVE: begin
                        if (w_empty) n_status = ST_EMPTY;
                    end
                    default: ;
                endcase
            end
            S_SCAN_RD: w_rd_addr = r_idx[AW-1:0];
            S_SCAN_EV: begin
                if (w_hit) begin
                    n_pos = r_idx;
                    unique case (r_cmd)
                        CMD_PRIO_PUSH: n_idx = r_occ;
                        CMD_QUERY:     n_found = 1'b1;
                        default: begin
                            if (r_cmd == CMD_POP) begin
                                n_res_id    = w_rd_id;
                                n_res_valid = 1'b1;
                            end
                            if (w_scan_last) n_occ = r_occ - CW'(1);
                            else             n_first = 1'b1;
                        end
                    endcase
                end else if (w_scan_last) begin
                    n_pos = r_occ;
                    if (r_cmd == CMD_REMOVE) n_status = ST_ABSENT;
                end else begin
                    n_idx = w_idx_p1;
                end
            end
            S_UP_RD: w_rd_addr = w_idx_m1[AW-1:0];
            S_UP_WR: begin
                w_wr_en = 1'b1;
                if (!w_up_last) n_idx = w_idx_m1;
            end
            S_INS: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos[AW-1:0];
                w_wr_data = {r_id, r_prio};
                n_occ     = r_occ + CW'(1);
            end
            S_DN_RD: w_rd_addr = w_idx_p1[AW-1:0];
            S_DN_WR: begin
                w_wr_en = 1'b1;
                n_first = 1'b0;
                // first word moved down is the follower of the removed entry
                if (r_first && r_cmd == CMD_REMOVE) begin
                    n_res_id    = w_rd_id;
                    n_res_valid = 1'b1;
                end
                if (w_dn_last) n_occ = r_occ - CW'(1);
                else           n_idx = w_idx_p1;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (w_out_load)   r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_res_id    <= n_res_id;
        r_res_valid <= n_res_valid;
        r_status    <= n_status;
        r_found     <= n_found;
        r_first     <= n_first;
        if (w_accept) begin
            r_cmd  <= i_command;
            r_id   <= w_id_in[ID_BITS-1:0];
            r_prio <= w_prio_in[PRIO_BITS-1:0];
        end
        if (w_out_load) begin
            r_out_id     <= w_res_ext[ID_W-1:0];
            r_out_rvalid <= r_res_valid;
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_empty  <= w_empty;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_result_id    = r_out_id;
    assign o_result_valid = r_out_rvalid;
    assign o_status       = r_out_status;
    assign o_found        = r_out_found;
    assign o_now_empty    = r_out_empty;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS |-> !w_full)
        else $error("insert into a full queue");

    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_WR || r_state == S_UP_WR) |-> !w_empty)
        else $error("shift on an empty queue");

    a_found_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> !o_now_empty)
        else $error("found reported on an empty queue");

    a_rvalid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_valid) |-> (o_status == ST_OK))
        else $error("result id given with an error status");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for priority_ready_queue_unit, directed table then random
// depends on prq_pkg and priority_ready_queue_unit; holds its own ordered-queue predictor

module testbench;
    import prq_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 60;

    // command codes the block treats as no operation
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ID_W-1:0] rid;
        logic            rvalid;
        t_status         status;
        logic            found;
        logic            empty;
    } result_word_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [4:0]        reps;
        logic              typed;
        result_word_t      want;
    } stim_row_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [CMD_W-1:0]    i_command;
    logic [ID_W-1:0]     i_task_id;
    logic [PRIO_W-1:0]   i_task_priority;
    logic                o_valid;
    logic                i_ready;
    logic [ID_W-1:0]     o_result_id;
    logic                o_result_valid;
    logic [STATUS_W-1:0] o_status;
    logic                o_found;
    logic                o_now_empty;

    // predictor copy of the queue, head at index 0
    logic [ID_W-1:0]   held_id   [QDEPTH];
    logic [PRIO_W-1:0] held_prio [QDEPTH];
    int                held_count = 0;

    result_word_t due_results[$];
    int           err_count   = 0;
    int           tx_idle_pct = 23;
    int           rx_idle_pct = 76;
    bit           hold_req    = 1'b0;
    bit           fill_phase  = 1'b1;

    // typed rows carry the expected word; the rest go through the predictor
    stim_row_t directed_rows [0:18] = '{
        '{CMD_POP,       8'h00, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, ST_EMPTY,  1'b0, 1'b1}},
        '{CMD_REMOVE,    8'h12, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, ST_EMPTY,  1'b0, 1'b1}},
        '{CMD_QUERY,     8'h12, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, ST_OK,     1'b0, 1'b1}},
        '{CMD_SPARE_HI,  8'hFF, 8'hFF, 5'd1,  1'b1, '{8'h00, 1'b0, ST_OK,     1'b0, 1'b1}},
        '{CMD_PUSH,      8'hFF, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, ST_OK,     1'b0, 1'b0}},
        '{CMD_PRIO_PUSH, 8'h00, 8'hFF, 5'd1,  1'b0, '0},
        '{CMD_PRIO_PUSH, 8'h55, 8'hFF, 5'd1,  1'b0, '0},
        '{CMD_PRIO_PUSH, 8'hAA, 8'h80, 5'd1,  1'b0, '0},
        '{CMD_PUSH,      8'hAA, 8'h07, 5'd1,  1'b0, '0},
        '{CMD_QUERY,     8'hAA, 8'h00, 5'd1,  1'b0, '0},
        '{CMD_REMOVE,    8'h12, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, ST_ABSENT, 1'b0, 1'b0}},
        '{CMD_REMOVE,    8'hAA, 8'h00, 5'd1,  1'b0, '0},
        '{CMD_REMOVE,    8'hAA, 8'h00, 5'd1,  1'b0, '0},
        '{CMD_SPARE_LO,  8'h00, 8'h00, 5'd1,  1'b1, '{8'h00, 1'b0, ST_OK,     1'b0, 1'b0}},
        '{CMD_PRIO_PUSH, 8'h30, 8'h80, 5'd13, 1'b0, '0},
        '{CMD_PUSH,      8'h77, 8'h01, 5'd1,  1'b1, '{8'h00, 1'b0, ST_FULL,   1'b0, 1'b0}},
        '{CMD_PRIO_PUSH, 8'h78, 8'hFF, 5'd1,  1'b1, '{8'h00, 1'b0, ST_FULL,   1'b0, 1'b0}},
        '{CMD_QUERY,     8'h3C, 8'h00, 5'd1,  1'b0, '0},
        '{CMD_POP,       8'h00, 8'h00, 5'd1,  1'b0, '0}
    };

    priority_ready_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_task_id       (i_task_id),
        .i_task_priority (i_task_priority),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_id     (o_result_id),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_now_empty     (o_now_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int locate_id(input logic [ID_W-1:0] id);
        for (int k = 0; k < held_count; k++) begin
            if (held_id[k] == id) return k;
        end
        return held_count;
    endfunction

    function automatic void drop_entry(input int pos);
        for (int k = pos; k + 1 < held_count; k++) begin
            held_id[k]   = held_id[k + 1];
            held_prio[k] = held_prio[k + 1];
        end
        held_count--;
    endfunction

    function automatic result_word_t apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [PRIO_W-1:0] prio);
        result_word_t r;
        int pos;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH, CMD_PRIO_PUSH: begin
                if (held_count >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = held_count;
                    // priority insert goes ahead of the first strictly lower entry
                    if (cmd == CMD_PRIO_PUSH) begin
                        pos = 0;
                        while (pos < held_count && prio <= held_prio[pos]) pos++;
                    end
                    for (int k = held_count; k > pos; k--) begin
                        held_id[k]   = held_id[k - 1];
                        held_prio[k] = held_prio[k - 1];
                    end
                    held_id[pos]   = id;
                    held_prio[pos] = prio;
                    held_count++;
                end
            end
            CMD_POP: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.rid    = held_id[0];
                    r.rvalid = 1'b1;
                    drop_entry(0);
                end
            end
            CMD_REMOVE: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = locate_id(id);
                    if (pos >= held_count) begin
                        r.status = ST_ABSENT;
                    end else begin
                        if (pos + 1 < held_count) begin
                            r.rid    = held_id[pos + 1];
                            r.rvalid = 1'b1;
                        end
                        drop_entry(pos);
                    end
                end
            end
            CMD_QUERY: begin
                r.found = (locate_id(id) < held_count);
            end
            default: begin
            end
        endcase
        r.empty = (held_count == 0);
        return r;
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [PRIO_W-1:0] prio, input logic typed,
                             input result_word_t want);
        result_word_t pred;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_command       = cmd;
        i_task_id       = id;
        i_task_priority = prio;
        do @(posedge i_clk); while (!o_ready);
        pred = apply_command(cmd, id, prio);
        due_results.push_back(typed ? want : pred);
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic offer_random(input int n);
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        int                roll;
        for (int k = 0; k < n; k++) begin
            // swing between filling and draining so both full and empty are hit often
            if (held_count == QDEPTH) fill_phase = 1'b0;
            else if (held_count == 0) fill_phase = 1'b1;
            else if ($urandom_range(24) == 0) fill_phase = !fill_phase;
            roll = $urandom_range(99);
            if (roll < 4) cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
            else if (roll < 14) cmd = CMD_QUERY;
            else if (roll < (fill_phase ? 44 : 24)) cmd = CMD_PUSH;
            else if (roll < (fill_phase ? 74 : 34)) cmd = CMD_PRIO_PUSH;
            else if (roll < (fill_phase ? 86 : 67)) cmd = CMD_POP;
            else cmd = CMD_REMOVE;
            // lookups mostly target queued ids; small id pool makes duplicates
            if ((cmd == CMD_REMOVE || cmd == CMD_QUERY) && held_count > 0
                && $urandom_range(9) < 7)
                id = held_id[$urandom_range(held_count - 1)];
            else if ($urandom_range(1)) id = ID_W'($urandom_range(15));
            else id = ID_W'($urandom);
            case ($urandom_range(3))
                0: prio = PRIO_W'($urandom_range(3));
                1: prio = $urandom_range(1) ? 8'hFF : 8'h00;
                default: prio = PRIO_W'($urandom);
            endcase
            send_word(cmd, id, prio, 1'b0, '0);
        end
    endtask

    task automatic flag_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        err_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        result_word_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t ns: stray word, expected none, actual id %0d status %0d",
                         $time, o_result_id, o_status);
                err_count++;
            end else begin
                want = due_results.pop_front();
                if (o_result_id !== want.rid) flag_field("result_id", want.rid, o_result_id);
                if (o_result_valid !== want.rvalid)
                    flag_field("result_valid", want.rvalid, o_result_valid);
                if (o_status !== want.status) flag_field("status", want.status, o_status);
                if (o_found !== want.found) flag_field("found", want.found, o_found);
                if (o_now_empty !== want.empty) flag_field("now_empty", want.empty, o_now_empty);
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) stalled = 0;
            else stalled++;
        end
        $display("priority_ready_queue_unit verification failed");
        $finish;
    end

    initial begin : stimulus
        stim_row_t row;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_command       = CMD_PUSH;
        i_task_id       = '0;
        i_task_priority = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < 19; r++) begin
            row = directed_rows[r];
            for (int k = 0; k < row.reps; k++)
                send_word(row.cmd, row.id + ID_W'(k), row.prio, row.typed, row.want);
        end

        // receiver goes quiet while words keep coming, so the block backs up
        hold_req = 1'b1;
        offer_random(225);
        pause_until_drained();

        tx_idle_pct = 76;
        rx_idle_pct = 23;
        offer_random(225);
        pause_until_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        offer_random(220);
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("priority_ready_queue_unit verification clean");
        end else begin
            $display("priority_ready_queue_unit verification failed");
        end
        $finish;
    end

endmodule
